[rtl/gfse_pkg.sv]
// Package with the shared types, codes and defaults of the grammar FIRST-set engine.
package gfse_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int NUM_NONTERMINALS_DEF = 16;
    localparam int NUM_TERMINALS_DEF    = 32;
    localparam int MAX_SYMBOLS_DEF      = 256;

    // A set holds 32 terminal bits and the empty-string bit on top.
    localparam int SET_W = 33;
    localparam logic [SET_W-1:0] EPS_MASK = {1'b1, 32'h0000_0000};

    // Operation codes.
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // Symbol kinds; the unused code behaves as an empty symbol.
    localparam logic [1:0] KIND_TERM    = 2'd0;
    localparam logic [1:0] KIND_NONTERM = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] head;
        logic [1:0] symbol_kind;
        logic [4:0] symbol_index;
        logic       production_end;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0]  nonterminal;
        logic [31:0] first_terminals;
        logic        derives_empty;
        logic        store_overflowed;
        logic        last;
    } rsp_item_t;

    // One stored production symbol.
    typedef struct packed {
        logic       prod_end;
        logic [4:0] symbol_index;
        logic [1:0] symbol_kind;
        logic [3:0] head;
    } prod_entry_t;

    // Result of the shared set merge unit.
    typedef struct packed {
        logic [SET_W-1:0] value;
        logic             grew;
        logic             has_eps;
    } merge_res_t;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_SYM_RD    = 9'b000000010,
        ST_SYM_EVAL  = 9'b000000100,
        ST_SET_EVAL  = 9'b000001000,
        ST_SYM_END   = 9'b000010000,
        ST_HEAD_EVAL = 9'b000100000,
        ST_PASS_END  = 9'b001000000,
        ST_EMIT_RD   = 9'b010000000,
        ST_EMIT_LOAD = 9'b100000000
    } state_t;

endpackage

[rtl/grammar_first_set_engine_top.sv]
// Operation: a load, clear or unused operation is handled in the idle state; compute runs
// passes over all stored symbols until a pass grows no set, then emits one result per
// nonterminal, holding it while the receiver stalls. Throughput: one item at a time; the
// pass count is at most the number of set growths plus one, so the pass loop sets the time.
// Reset: counters, overflow flag and all FIRST sets clear at once (valid bits); the
// production memory is not cleared and needs no clearing pass.
module grammar_first_set_engine_top
    import gfse_pkg::*;
#(
    parameter int NUM_NONTERMINALS = NUM_NONTERMINALS_DEF,
    parameter int NUM_TERMINALS    = NUM_TERMINALS_DEF,
    parameter int MAX_SYMBOLS      = MAX_SYMBOLS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    // Address width of the production memory and width of the fill count.
    localparam int AW = $clog2(MAX_SYMBOLS);
    localparam int CW = $clog2(MAX_SYMBOLS + 1);
    // Address width of the FIRST-set memory.
    localparam int NW = $clog2(NUM_NONTERMINALS);

    // Sequencer state and control registers.
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic [CW-1:0]   p_reg, p_next;
    logic [NW-1:0]   k_reg, k_next;
    logic            start_reg, start_next;
    logic            done_reg, done_next;
    logic            changed_reg, changed_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // Data registers of the scan and the output.
    logic [3:0]       head_reg, head_next;
    logic [SET_W-1:0] acc_reg, acc_next;
    rsp_item_t        rsp_reg, rsp_next;

    // Memory and merge unit hookup.
    logic             st_wr_en;
    prod_entry_t      st_wr_data;
    prod_entry_t      ent;
    logic             set_clr;
    logic             set_wr_en;
    logic [NW-1:0]    set_wr_addr;
    logic [SET_W-1:0] set_wr_data;
    logic [NW-1:0]    set_rd_addr;
    logic [SET_W-1:0] set_rd_data;
    logic [SET_W-1:0] mu_base;
    logic [SET_W-1:0] mu_operand;
    logic             mu_mask_eps;
    merge_res_t       mu_res;

    // Decoded views of the symbol currently read from the production memory.
    logic             cmd_take;
    logic             is_last_sym;
    logic             is_end;
    logic [6:0]       idx_ext;
    logic [6:0]       head_ext;
    logic [6:0]       k_ext;
    logic             nt_ok;
    logic             head_ok;
    logic             term_ok;
    logic [SET_W-1:0] term_operand;
    logic [SET_W-1:0] acc_base;
    logic             done_base;
    logic             do_advance;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_take  = cmd_valid & ~cmd_stall;

    assign st_wr_data.prod_end     = cmd.production_end;
    assign st_wr_data.symbol_index = cmd.symbol_index;
    assign st_wr_data.symbol_kind  = cmd.symbol_kind;
    assign st_wr_data.head         = cmd.head;

    gfse_prod_store #(
        .DEPTH (MAX_SYMBOLS),
        .AW    (AW)
    ) u_prod_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (st_wr_data),
        .rd_addr (p_reg[AW-1:0]),
        .rd_data (ent)
    );

    gfse_set_store #(
        .DEPTH (NUM_NONTERMINALS),
        .AW    (NW)
    ) u_set_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (set_clr),
        .wr_en   (set_wr_en),
        .wr_addr (set_wr_addr),
        .wr_data (set_wr_data),
        .rd_addr (set_rd_addr),
        .rd_data (set_rd_data)
    );

    gfse_merge_unit u_merge (
        .base     (mu_base),
        .operand  (mu_operand),
        .mask_eps (mu_mask_eps),
        .res      (mu_res)
    );

    // The production memory address is the scan position and stays put while a symbol
    // is being worked on, so its registered read data holds for all of that symbol.
    always_comb
    begin
        is_last_sym  = ((p_reg + CW'(1)) == count_reg);
        is_end       = ent.prod_end | is_last_sym;
        idx_ext      = {2'b00, ent.symbol_index};
        head_ext     = {3'b000, head_reg};
        k_ext        = 7'(k_reg);
        nt_ok        = (idx_ext < 7'(NUM_NONTERMINALS));
        head_ok      = (head_ext < 7'(NUM_NONTERMINALS));
        term_ok      = ({1'b0, ent.symbol_index} < 6'(NUM_TERMINALS));
        term_operand = term_ok ? (SET_W'(1) << ent.symbol_index) : '0;
        // The first symbol of a production starts a fresh scan.
        acc_base     = start_reg ? '0 : acc_reg;
        done_base    = start_reg ? 1'b0 : done_reg;
    end

    // Operand selection of the shared merge unit. A terminal adds its bit, an empty or
    // spare symbol adds epsilon, a body nonterminal adds its set without epsilon, and
    // the head update folds the scan result into the stored set of the head.
    always_comb
    begin
        mu_base     = acc_reg;
        mu_operand  = EPS_MASK;
        mu_mask_eps = 1'b0;
        priority if (state_reg == ST_SYM_EVAL)
        begin
            mu_base    = acc_base;
            mu_operand = (ent.symbol_kind == KIND_TERM) ? term_operand : EPS_MASK;
        end
        else if (state_reg == ST_SET_EVAL)
        begin
            mu_operand  = set_rd_data;
            mu_mask_eps = 1'b1;
        end
        else if (state_reg == ST_HEAD_EVAL)
        begin
            mu_base    = set_rd_data;
            mu_operand = acc_reg;
        end
        else
        begin
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        start_next     = start_reg;
        done_next      = done_reg;
        changed_next   = changed_reg;
        rsp_valid_next = rsp_valid_reg;
        head_next      = head_reg;
        acc_next       = acc_reg;
        rsp_next       = rsp_reg;

        st_wr_en    = 1'b0;
        set_clr     = 1'b0;
        set_wr_en   = 1'b0;
        set_wr_addr = head_ext[NW-1:0];
        set_wr_data = mu_res.value;
        set_rd_addr = k_reg;
        do_advance  = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    unique case (cmd.operation)
                        OP_LOAD:
                        begin
                            if (count_reg < CW'(MAX_SYMBOLS))
                            begin
                                st_wr_en   = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next   = '0;
                            ovf_next     = 1'b0;
                            changed_next = 1'b0;
                            set_clr      = 1'b1;
                        end
                        OP_COMPUTE:
                        begin
                            set_clr      = 1'b1;
                            changed_next = 1'b0;
                            k_next       = '0;
                            p_next       = '0;
                            start_next   = 1'b1;
                            if (count_reg == '0)
                            begin
                                state_next = ST_EMIT_RD;
                            end
                            else
                            begin
                                state_next = ST_SYM_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SYM_RD:
            begin
                state_next = ST_SYM_EVAL;
            end

            ST_SYM_EVAL:
            begin
                head_next  = start_reg ? ent.head : head_reg;
                start_next = 1'b0;
                acc_next   = acc_base;
                done_next  = done_base;
                state_next = ST_SYM_END;
                if (!done_base)
                begin
                    unique case (ent.symbol_kind)
                        KIND_TERM:
                        begin
                            acc_next  = mu_res.value;
                            done_next = 1'b1;
                        end
                        KIND_NONTERM:
                        begin
                            if (nt_ok)
                            begin
                                set_rd_addr = idx_ext[NW-1:0];
                                state_next  = ST_SET_EVAL;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            acc_next  = mu_res.value;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_SET_EVAL:
            begin
                acc_next   = mu_res.value;
                done_next  = ~mu_res.has_eps;
                state_next = ST_SYM_END;
            end

            ST_SYM_END:
            begin
                if (is_end && head_ok)
                begin
                    set_rd_addr = head_ext[NW-1:0];
                    acc_next    = done_reg ? acc_reg : (acc_reg | EPS_MASK);
                    state_next  = ST_HEAD_EVAL;
                end
                else
                begin
                    do_advance = 1'b1;
                end
            end

            ST_HEAD_EVAL:
            begin
                set_wr_en   = 1'b1;
                set_wr_addr = head_ext[NW-1:0];
                set_wr_data = mu_res.value;
                if (mu_res.grew)
                begin
                    changed_next = 1'b1;
                end
                do_advance = 1'b1;
            end

            ST_PASS_END:
            begin
                if (changed_reg)
                begin
                    changed_next = 1'b0;
                    p_next       = '0;
                    start_next   = 1'b1;
                    state_next   = ST_SYM_RD;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end

            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LOAD;
            end

            ST_EMIT_LOAD:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.nonterminal      = k_ext[3:0];
                    rsp_next.first_terminals  = set_rd_data[31:0];
                    rsp_next.derives_empty    = set_rd_data[SET_W-1];
                    rsp_next.store_overflowed = ovf_reg;
                    rsp_next.last             = (k_reg == NW'(NUM_NONTERMINALS - 1));
                    if (k_reg == NW'(NUM_NONTERMINALS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + NW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Step to the next stored symbol, or close the pass after the last one.
        if (do_advance)
        begin
            start_next = is_end;
            if (is_last_sym)
            begin
                state_next = ST_PASS_END;
            end
            else
            begin
                p_next     = p_reg + CW'(1);
                state_next = ST_SYM_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            p_reg         <= '0;
            k_reg         <= '0;
            start_reg     <= 1'b0;
            done_reg      <= 1'b0;
            changed_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            p_reg         <= p_next;
            k_reg         <= k_next;
            start_reg     <= start_next;
            done_reg      <= done_next;
            changed_reg   <= changed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        acc_reg  <= acc_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    // The fill count never runs past the capacity of the production memory.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SYMBOLS))
        else $error("symbol count beyond capacity");

    // The overflow flag only rises on a load that found the store full.
    a_ovf_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> $past(cmd_take && (cmd.operation == OP_LOAD)
                                 && (count_reg == CW'(MAX_SYMBOLS))))
        else $error("overflow flag set without a dropped load");

    // A result that is not the final one leaves only while the emit loop is running.
    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && !rsp.last) |->
            ((state_reg == ST_EMIT_RD) || (state_reg == ST_EMIT_LOAD)))
        else $error("result handed over outside the emit loop");
`endif

endmodule

[rtl/gfse_prod_store.sv]
// Production symbol memory: one write port and one registered read port.
module gfse_prod_store
    import gfse_pkg::*;
#(
    parameter int DEPTH = MAX_SYMBOLS_DEF,
    parameter int AW    = $clog2(MAX_SYMBOLS_DEF)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  prod_entry_t   wr_data,
    input  logic [AW-1:0] rd_addr,
    output prod_entry_t   rd_data
);

    prod_entry_t mem [DEPTH];
    prod_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/gfse_set_store.sv]
// FIRST-set memory with per-entry valid bits so that a single clear strobe empties every entry.
module gfse_set_store
    import gfse_pkg::*;
#(
    parameter int DEPTH = NUM_NONTERMINALS_DEF,
    parameter int AW    = $clog2(NUM_NONTERMINALS_DEF)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [SET_W-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [SET_W-1:0] rd_data
);

    logic [SET_W-1:0] mem [DEPTH];
    logic [SET_W-1:0] rd_mem_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // An entry never written since the last clear reads as the empty set.
    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

[rtl/gfse_merge_unit.sv]
// Shared set merge unit: ORs an operand set, optionally without epsilon, into a base set and flags growth.
module gfse_merge_unit
    import gfse_pkg::*;
(
    input  logic [SET_W-1:0] base,
    input  logic [SET_W-1:0] operand,
    input  logic             mask_eps,
    output merge_res_t       res
);

    logic [SET_W-1:0] operand_eff;

    always_comb
    begin
        operand_eff = mask_eps ? (operand & ~EPS_MASK) : operand;
        res.value   = base | operand_eff;
        res.grew    = (res.value != base);
        res.has_eps = operand[SET_W-1];
    end

endmodule

[test/first_set_monitor.sv]
// Monitor for the FIRST-set engine: predicts the result items of every compute and compares them.
module first_set_monitor
    import gfse_pkg::*;
#(
    parameter int NUM_NONTERMINALS = NUM_NONTERMINALS_DEF,
    parameter int NUM_TERMINALS    = NUM_TERMINALS_DEF,
    parameter int MAX_SYMBOLS      = MAX_SYMBOLS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_stall,
    input  cmd_item_t cmd,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_item_t rsp,
    output int        fail_count,
    output int        outstanding
);

    prod_entry_t      grammar [MAX_SYMBOLS];
    int               symbol_total = 0;
    logic             dropped = 1'b0;
    logic [SET_W-1:0] first_of [NUM_NONTERMINALS];
    rsp_item_t        expected_sets [$];

    // FIRST of the body held in grammar[lo] up to, not including, grammar[hi].
    function automatic logic [SET_W-1:0] body_first(int lo, int hi);
        logic [SET_W-1:0] acc;
        prod_entry_t      e;
        acc = '0;
        for (int p = lo; p < hi; p++)
        begin
            e = grammar[p];
            if (e.symbol_kind == KIND_TERM)
            begin
                if (int'(e.symbol_index) < NUM_TERMINALS)
                    acc[e.symbol_index] = 1'b1;
                return acc;
            end
            else if (e.symbol_kind == KIND_NONTERM)
            begin
                // A nonterminal beyond the table has an empty set and cannot vanish.
                if (int'(e.symbol_index) >= NUM_NONTERMINALS)
                    return acc;
                acc = acc | (first_of[e.symbol_index] & ~EPS_MASK);
                if ((first_of[e.symbol_index] & EPS_MASK) == '0)
                    return acc;
            end
            else
            begin
                // The empty symbol and the spare kind both end the scan with epsilon.
                return acc | EPS_MASK;
            end
        end
        return acc | EPS_MASK;
    endfunction

    function automatic void compute_first_sets();
        int               start;
        logic             grew;
        logic [SET_W-1:0] merged;
        rsp_item_t        r;
        foreach (first_of[n])
            first_of[n] = '0;
        do
        begin
            grew  = 1'b0;
            start = 0;
            for (int p = 0; p < symbol_total; p++)
            begin
                if (grammar[p].prod_end || p + 1 == symbol_total)
                begin
                    if (int'(grammar[start].head) < NUM_NONTERMINALS)
                    begin
                        merged = first_of[grammar[start].head] | body_first(start, p + 1);
                        if (merged != first_of[grammar[start].head])
                            grew = 1'b1;
                        first_of[grammar[start].head] = merged;
                    end
                    start = p + 1;
                end
            end
        end
        while (grew);
        for (int n = 0; n < NUM_NONTERMINALS; n++)
        begin
            r.nonterminal      = 4'(n);
            r.first_terminals  = first_of[n][31:0];
            r.derives_empty    = first_of[n][SET_W-1];
            r.store_overflowed = dropped;
            r.last             = (n == NUM_NONTERMINALS - 1);
            expected_sets.push_back(r);
        end
    endfunction

    function automatic void apply_item(cmd_item_t item);
        case (item.operation)
            OP_LOAD:
            begin
                if (symbol_total < MAX_SYMBOLS)
                begin
                    grammar[symbol_total].prod_end     = item.production_end;
                    grammar[symbol_total].symbol_index = item.symbol_index;
                    grammar[symbol_total].symbol_kind  = item.symbol_kind;
                    grammar[symbol_total].head         = item.head;
                    symbol_total++;
                end
                else
                begin
                    dropped = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                symbol_total = 0;
                dropped      = 1'b0;
                foreach (first_of[n])
                    first_of[n] = '0;
            end
            OP_COMPUTE:
                compute_first_sets();
            default:
                ;
        endcase
    endfunction

    function automatic void report_field(string field, int nt, logic [31:0] want,
                                         logic [31:0] got);
        if (want != got)
            $display("%0t: result for nonterminal %0d, %s expected %h, got %h",
                     $time, nt, field, want, got);
    endfunction

    function automatic void check_result(rsp_item_t got);
        rsp_item_t want;
        if (expected_sets.size() == 0)
        begin
            $display("%0t: result item with none expected, got %p", $time, got);
            fail_count++;
            return;
        end
        want = expected_sets.pop_front();
        if (got != want)
        begin
            fail_count++;
            report_field("nonterminal", int'(want.nonterminal), 32'(want.nonterminal),
                         32'(got.nonterminal));
            report_field("first_terminals", int'(want.nonterminal), want.first_terminals,
                         got.first_terminals);
            report_field("derives_empty", int'(want.nonterminal), 32'(want.derives_empty),
                         32'(got.derives_empty));
            report_field("store_overflowed", int'(want.nonterminal),
                         32'(want.store_overflowed), 32'(got.store_overflowed));
            report_field("last", int'(want.nonterminal), 32'(want.last), 32'(got.last));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_total = 0;
            dropped      = 1'b0;
            expected_sets.delete();
            outstanding  = 0;
        end
        else
        begin
            // Results of an earlier compute leave the queue before new ones join it.
            if (rsp_valid && !rsp_stall)
                check_result(rsp);
            if (cmd_valid && !cmd_stall)
                apply_item(cmd);
            outstanding = expected_sets.size();
        end
    end

endmodule

[test/grammar_first_set_engine_top_test.sv]
// Top of the FIRST-set engine testbench: clock, reset, item stimulus, result stalls and verdict.
module grammar_first_set_engine_top_test;
    import gfse_pkg::*;

    // Codes the package leaves unnamed: the unused operation and the spare symbol kind.
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 140;
    // A compute over a full store with many passes is the longest quiet stretch.
    localparam int QUIET_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    int fail_count;
    int outstanding;
    int items_sent;
    int fill_items;
    bit hold_pending;
    bit sender_burst;
    bit receiver_burst;

    grammar_first_set_engine_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // The monitor sees every handshake on both channels and keeps the failure count.
    first_set_monitor i_monitor
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic cmd_item_t pack_cmd(logic [1:0] op, logic [3:0] head,
                                           logic [1:0] kind, logic [4:0] index,
                                           logic prod_last);
        cmd_item_t it;
        it.operation      = op;
        it.head           = head;
        it.symbol_kind    = kind;
        it.symbol_index   = index;
        it.production_end = prod_last;
        return it;
    endfunction

    // An operation item whose unused fields carry random bits.
    function automatic cmd_item_t op_item(logic [1:0] op);
        return pack_cmd(op, 4'($urandom), 2'($urandom), 5'($urandom), 1'($urandom));
    endfunction

    // Offers one item after a random gap and returns at the edge that accepts it.
    // Valid is only lowered when a gap follows, so a back-to-back item keeps it high.
    task automatic send_item(cmd_item_t it);
        int gap;
        if ($urandom_range(0, 15) == 0)
            sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= it;
        do
            @(posedge clk);
        while (cmd_stall);
        items_sent++;
    endtask

    task automatic load_symbol(logic [3:0] head, logic [1:0] kind, logic [4:0] index,
                               logic prod_last);
        send_item(pack_cmd(OP_LOAD, head, kind, index, prod_last));
    endtask

    // A body symbol drawn so that terminals and nonterminals dominate, with some empty
    // symbols, the spare kind and nonterminals beyond the table mixed in.
    function automatic cmd_item_t random_symbol(logic [3:0] head, int span, logic prod_last);
        int         pick;
        logic [1:0] kind;
        logic [4:0] index;
        pick  = $urandom_range(0, 19);
        index = 5'($urandom_range(0, 31));
        if (pick < 8)
            kind = KIND_TERM;
        else if (pick < 16)
        begin
            kind = KIND_NONTERM;
            if ($urandom_range(0, 9) != 0)
                index = 5'($urandom_range(0, span - 1));
            else
                index = 5'($urandom_range(16, 31));
        end
        else if (pick < 19)
            kind = KIND_EMPTY;
        else
            kind = KIND_SPARE;
        // Only the first symbol's head counts; now and then any symbol, the first included, carries a random head.
        if ($urandom_range(0, 9) == 0)
            head = 4'($urandom);
        return pack_cmd(OP_LOAD, head, kind, index, prod_last);
    endfunction

    // One production of one to four symbols. With open_tail set, the end mark is left
    // off, so the production runs into the next one or forms the unterminated tail.
    task automatic load_production(int span, bit open_tail);
        int         len;
        logic [3:0] head;
        if ($urandom_range(0, 7) == 0)
            head = 4'($urandom_range(0, 15));
        else
            head = 4'($urandom_range(0, span - 1));
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
            send_item(random_symbol(head, span, (i == len - 1) && !open_tail));
    endtask

    // A grammar phase: mostly a clear, a few random productions with some noise, then a
    // compute. A fill phase instead loads past the capacity of the production store.
    // With hold set, the receiver is told to hold off just as the compute goes out.
    task automatic grammar_phase(bit fill, bit hold);
        int span;
        int first_item;
        span = $urandom_range(2, 16);
        if (fill || $urandom_range(0, 6) != 0)
            send_item(op_item(OP_CLEAR));
        if (fill)
        begin
            first_item = items_sent;
            while (items_sent - first_item < MAX_SYMBOLS_DEF + 2)
                load_production(span, 1'b0);
            fill_items += items_sent - first_item;
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(op_item(OP_UNUSED));
                load_production(span, $urandom_range(0, 19) == 0);
            end
        end
        if (hold)
            hold_pending = 1'b1;
        send_item(op_item(OP_COMPUTE));
        if ($urandom_range(0, 7) == 0)
            send_item(op_item(OP_COMPUTE));
    endtask

    // Result side: a random stall before each result item, bursts with no stall, and one
    // long hold-off on request. The wait for a result also breaks off when a hold-off
    // is requested; no result is taken at such an edge unless valid was already high.
    initial
    begin : receiver
        int wait_cycles;
        rsp_stall = 1'b0;
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                wait_cycles  = HOLD_CYCLES;
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    receiver_burst = !receiver_burst;
                wait_cycles = receiver_burst ? 0 : $urandom_range(0, 4);
            end
            if (wait_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!rsp_valid && !hold_pending);
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int base;
        int phase;
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd          = '0;
        items_sent   = 0;
        fill_items   = 0;
        hold_pending = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // An empty store gives all-zero sets, and the unused operation is ignored.
        send_item(op_item(OP_COMPUTE));
        send_item(op_item(OP_UNUSED));

        // A small grammar that touches every scan rule:
        //   0 -> 1 2 t5     through two nullable nonterminals to a terminal
        //   1 -> t0 | eps   a nullable nonterminal
        //   2 -> spare kind behaves as the empty symbol
        //   3 -> t31        the top terminal
        //   4 -> N20 t1     a nonterminal beyond the table stops the scan with nothing
        //   15 -> 0 t7      the top head
        //   5 -> 3 1        stops at a nonterminal that cannot vanish
        //   6 -> 1 2        every symbol passed, so epsilon joins
        //   7 -> t2         the unterminated tail at the end of the store
        load_symbol(4'd0, KIND_NONTERM, 5'd1, 1'b0);
        load_symbol(4'd0, KIND_NONTERM, 5'd2, 1'b0);
        load_symbol(4'd0, KIND_TERM, 5'd5, 1'b1);
        load_symbol(4'd1, KIND_TERM, 5'd0, 1'b1);
        load_symbol(4'd1, KIND_EMPTY, 5'd0, 1'b1);
        load_symbol(4'd2, KIND_SPARE, 5'd31, 1'b1);
        load_symbol(4'd3, KIND_TERM, 5'd31, 1'b1);
        load_symbol(4'd4, KIND_NONTERM, 5'd20, 1'b0);
        load_symbol(4'd4, KIND_TERM, 5'd1, 1'b1);
        load_symbol(4'd15, KIND_NONTERM, 5'd0, 1'b0);
        load_symbol(4'd15, KIND_TERM, 5'd7, 1'b1);
        load_symbol(4'd5, KIND_NONTERM, 5'd3, 1'b0);
        load_symbol(4'd5, KIND_NONTERM, 5'd1, 1'b1);
        load_symbol(4'd6, KIND_NONTERM, 5'd1, 1'b0);
        load_symbol(4'd6, KIND_NONTERM, 5'd2, 1'b1);
        load_symbol(4'd7, KIND_TERM, 5'd2, 1'b0);
        send_item(op_item(OP_COMPUTE));

        // A clear empties the store again.
        send_item(op_item(OP_CLEAR));
        send_item(op_item(OP_COMPUTE));

        // Random grammars. The second phase carries the long receiver hold-off while the
        // next phase keeps offering items; the fourth fills the store past capacity and
        // does not count toward the random item total.
        base  = items_sent;
        phase = 0;
        while (items_sent - fill_items - base < RANDOM_ITEMS)
        begin
            grammar_phase(phase == 3, phase == 1);
            phase++;
        end
        cmd_valid <= 1'b0;

        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
